>>> hw/rtl/nrp_pkg.sv
// Package for the H.264 NAL unit RTP packetiser: payload beat types,
// widths, register indexes, NAL header constants and reset values.
// No dependencies; imported by every module of the block.
`default_nettype none

package nrp_pkg;

   // Field widths
   localparam int LENGTH_BITS  = 20;
   localparam int PAYLOAD_BITS = 12;
   localparam int SEQ_BITS     = 16;
   localparam int STAMP_BITS   = 32;
   localparam int BYTE_BITS    = 8;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 2;

   // Common width for comparing lengths against the payload limit
   localparam int WIDE_BITS =
      ((LENGTH_BITS > PAYLOAD_BITS) ? LENGTH_BITS : PAYLOAD_BITS) + 1;

   // Result beats one input byte can cause, and the output queue
   localparam int MAX_BEATS       = 3;
   localparam int BEAT_COUNT_BITS = $clog2(MAX_BEATS + 1);
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_PAYLOAD   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STAMP_STEP    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEQ_INITIAL   = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STAMP_INITIAL = 2'd3;

   // Register reset values
   localparam logic [PAYLOAD_BITS-1:0] MAX_PAYLOAD_RESET   = PAYLOAD_BITS'(1400);
   localparam logic [STAMP_BITS-1:0]   STAMP_STEP_RESET    = STAMP_BITS'(90000 / 25);
   localparam logic [SEQ_BITS-1:0]     SEQ_INITIAL_RESET   = '0;
   localparam logic [STAMP_BITS-1:0]   STAMP_INITIAL_RESET = '0;

   // NAL header and FU-A constants
   localparam logic [BYTE_BITS-1:0] TYPE_MASK = 8'h1F;
   localparam logic [BYTE_BITS-1:0] NRI_MASK  = 8'h60;
   localparam logic [BYTE_BITS-1:0] FU_A_TYPE = 8'd28;
   localparam logic [BYTE_BITS-1:0] FU_START  = 8'h80;
   localparam logic [BYTE_BITS-1:0] FU_END    = 8'h40;
   localparam logic [BYTE_BITS-1:0] NAL_SPS   = 8'd7;
   localparam logic [BYTE_BITS-1:0] NAL_PPS   = 8'd8;

   // Input beat
   typedef struct packed {
      logic [BYTE_BITS-1:0]   nal_byte;
      logic [LENGTH_BITS-1:0] nal_length;
   } req_payload_type;

   // Result beat
   typedef struct packed {
      logic [BYTE_BITS-1:0]  out_byte;
      logic                  packet_first;
      logic                  packet_last;
      logic [SEQ_BITS-1:0]   seq_number;
      logic [STAMP_BITS-1:0] time_stamp;
   } rsp_payload_type;

   // Up to three result beats written into the output queue in one cycle
   typedef struct packed {
      logic [BEAT_COUNT_BITS-1:0]          count;
      rsp_payload_type [MAX_BEATS-1:0]     beat;
   } queue_push_type;

endpackage : nrp_pkg

`default_nettype wire

>>> hw/rtl/nrp_queue.sv
// Output queue of the packetiser: takes up to three result beats per cycle
// and hands them out one per cycle on the rsp channel while rsp_stall is low. Depends on nrp_pkg.
`default_nettype none

module nrp_queue (
   input  wire                       clock,
   input  wire                       reset,
   input  nrp_pkg::queue_push_type   push,
   output logic                      has_room,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output nrp_pkg::rsp_payload_type  rsp_payload
);
   import nrp_pkg::*;

   rsp_payload_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0]   count_ff, count_in;
   logic                        pop;

   // Room for a whole burst of beats from one input byte
   assign has_room    = count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH - MAX_BEATS);
   assign rsp_valid   = count_ff != '0;
   assign rsp_payload = entry_ff[rd_ptr_ff];
   assign pop         = rsp_valid && !rsp_stall;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_BITS'(push.count);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_BITS'(pop);
      count_in  = count_ff - QUEUE_CNT_BITS'(pop) + QUEUE_CNT_BITS'(push.count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed beats in order after the write pointer
   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_BEATS; k++) begin
         if (int'(push.count) > k) begin
            entry_ff[wr_ptr_ff + QUEUE_PTR_BITS'(k)] <= push.beat[k];
         end
      end
   end

endmodule : nrp_queue

`default_nettype wire

>>> hw/rtl/h264_nal_rtp_packetizer.sv
// H.264 NAL unit RTP packetiser, top level: unit tracking, FU-A header
// generation, sequence and timestamp counters. Depends on nrp_pkg, nrp_queue.
//
// Usage:
//   req channel: one NAL unit byte per beat, header byte first, start code
//   removed; nal_length is sampled on the header byte only.
//   rsp channel: RTP payload bytes, each tagged with packet_first,
//   packet_last, seq_number and time_stamp of its packet.
//   csr port: write max_payload, stamp_step, seq_initial, stamp_initial
//   between units; writing seq_initial or stamp_initial also loads the
//   running counter.
// Output: a byte's result beats are registered in the output queue when the
//   byte is accepted, and are offered from the head of that queue.
// Throughput: one byte per cycle while the queue has room. The header byte of a
//   fragmented unit gives no beat; the first byte of each fragment gives three
//   (indicator, FU header, byte), so the four-entry output queue stalls req there.
// Reset: registers return to their defaults, counters load the initial
//   values and the block waits for a NAL header byte.
// Receiver stall: beats wait in the output queue; req stalls once fewer than
//   three entries are free.
`default_nettype none

module h264_nal_rtp_packetizer (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire                                       req_valid,
   output logic                                      req_stall,
   input  nrp_pkg::req_payload_type                  req_payload,
   output logic                                      rsp_valid,
   input  wire                                       rsp_stall,
   output nrp_pkg::rsp_payload_type                  rsp_payload,
   input  wire                                       csr_write_enable,
   input  wire [nrp_pkg::CSR_INDEX_BITS-1:0]         csr_index,
   input  wire [nrp_pkg::CSR_DATA_BITS-1:0]          csr_write_data
);
   import nrp_pkg::*;

   // Configuration registers
   logic [PAYLOAD_BITS-1:0] max_payload_ff;
   logic [STAMP_BITS-1:0]   stamp_step_ff;

   // Unit state
   logic [LENGTH_BITS-1:0]  position_ff, position_in;
   logic [LENGTH_BITS-1:0]  length_ff, length_in;
   logic [BYTE_BITS-1:0]    header_ff, header_in;
   logic                    frag_mode_ff, frag_mode_in;
   logic [PAYLOAD_BITS-1:0] frag_fill_ff, frag_fill_in;
   logic [SEQ_BITS-1:0]     seq_ff, seq_in;
   logic [STAMP_BITS-1:0]   stamp_ff, stamp_in;

   logic                    accept;
   logic                    has_room;
   logic                    header_beat;
   logic                    unit_end;
   logic                    frag_last;
   logic [PAYLOAD_BITS-1:0] eff_payload;
   logic [LENGTH_BITS-1:0]  req_length;
   logic [BYTE_BITS-1:0]    nal_type;
   logic [BYTE_BITS-1:0]    fu_header;
   queue_push_type          push;

   assign req_stall = !has_room;
   assign accept    = req_valid && has_room;

   // Unit decode from the incoming byte and the stored state
   always_comb begin
      eff_payload  = (max_payload_ff == '0) ? PAYLOAD_BITS'(1) : max_payload_ff;
      req_length   = (req_payload.nal_length == '0) ? LENGTH_BITS'(1)
                                                    : req_payload.nal_length;
      header_beat  = position_ff == '0;
      length_in    = header_beat ? req_length : length_ff;
      header_in    = header_beat ? req_payload.nal_byte : header_ff;
      frag_mode_in = header_beat ? (WIDE_BITS'(req_length) > WIDE_BITS'(eff_payload))
                                 : frag_mode_ff;
      unit_end     = (WIDE_BITS'(position_ff) + WIDE_BITS'(1)) >= WIDE_BITS'(length_in);
      nal_type     = header_in & TYPE_MASK;
      frag_last    = unit_end ||
                     ((WIDE_BITS'(frag_fill_ff) + WIDE_BITS'(1)) >= WIDE_BITS'(eff_payload));
      fu_header    = nal_type;
      if (position_ff == LENGTH_BITS'(1)) begin
         fu_header = fu_header | FU_START;
      end
      if ((WIDE_BITS'(length_in) - WIDE_BITS'(position_ff)) <= WIDE_BITS'(eff_payload)) begin
         fu_header = fu_header | FU_END;
      end
   end

   // Build result beats and next counter values
   always_comb begin
      push.count   = '0;
      for (int k = 0; k < MAX_BEATS; k++) begin
         push.beat[k].out_byte     = req_payload.nal_byte;
         push.beat[k].packet_first = 1'b0;
         push.beat[k].packet_last  = 1'b0;
         push.beat[k].seq_number   = seq_ff;
         push.beat[k].time_stamp   = stamp_ff;
      end
      seq_in       = seq_ff;
      stamp_in     = stamp_ff;
      frag_fill_in = header_beat ? '0 : frag_fill_ff;

      if (!frag_mode_in) begin
         // Single-unit packet: pass the byte through
         push.count                = BEAT_COUNT_BITS'(1);
         push.beat[0].packet_first = header_beat;
         push.beat[0].packet_last  = unit_end;
         if (unit_end) begin
            seq_in = seq_ff + SEQ_BITS'(1);
            if (nal_type != NAL_SPS && nal_type != NAL_PPS) begin
               stamp_in = stamp_ff + stamp_step_ff;
            end
         end
      end else if (!header_beat) begin
         // FU-A fragment: prepend indicator and FU header on its first byte
         if (frag_fill_ff == '0) begin
            push.count                = BEAT_COUNT_BITS'(3);
            push.beat[0].out_byte     = (header_in & NRI_MASK) | FU_A_TYPE;
            push.beat[0].packet_first = 1'b1;
            push.beat[1].out_byte     = fu_header;
            push.beat[2].packet_last  = frag_last;
         end else begin
            push.count               = BEAT_COUNT_BITS'(1);
            push.beat[0].packet_last = frag_last;
         end
         if (frag_last) begin
            frag_fill_in = '0;
            seq_in       = seq_ff + SEQ_BITS'(1);
         end else begin
            frag_fill_in = frag_fill_ff + PAYLOAD_BITS'(1);
         end
         if (unit_end) begin
            stamp_in = stamp_ff + stamp_step_ff;
         end
      end

      if (unit_end) begin
         position_in  = '0;
         frag_fill_in = '0;
      end else begin
         position_in  = position_ff + LENGTH_BITS'(1);
      end

      // Drop the beats unless the byte is taken
      if (!accept) begin
         push.count = '0;
      end
   end

   // Configuration registers and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff   <= MAX_PAYLOAD_RESET;
         stamp_step_ff    <= STAMP_STEP_RESET;
         seq_ff           <= SEQ_INITIAL_RESET;
         stamp_ff         <= STAMP_INITIAL_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAX_PAYLOAD: begin
               max_payload_ff <= csr_write_data[PAYLOAD_BITS-1:0];
            end
            CSR_STAMP_STEP: begin
               stamp_step_ff <= csr_write_data[STAMP_BITS-1:0];
            end
            CSR_SEQ_INITIAL: begin
               seq_ff <= csr_write_data[SEQ_BITS-1:0];
            end
            CSR_STAMP_INITIAL: begin
               stamp_ff <= csr_write_data[STAMP_BITS-1:0];
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         seq_ff   <= seq_in;
         stamp_ff <= stamp_in;
      end
   end

   // Unit tracking state
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         length_ff    <= '0;
         header_ff    <= '0;
         frag_mode_ff <= 1'b0;
         frag_fill_ff <= '0;
      end else if (accept) begin
         position_ff  <= position_in;
         length_ff    <= length_in;
         header_ff    <= header_in;
         frag_mode_ff <= frag_mode_in;
         frag_fill_ff <= frag_fill_in;
      end
   end

   // Output queue
   nrp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .has_room    (has_room),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule : h264_nal_rtp_packetizer

`default_nettype wire

>>> tb/testbench.sv
// Self-checking bench for h264_nal_rtp_packetizer: drives NAL unit bytes with random
// gaps and receiver stalls, predicts every RTP payload beat and compares each one.
// Depends on nrp_pkg and the packetiser RTL only.
`default_nettype none

module testbench;
   import nrp_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_BYTES = 470;
   localparam int DRAIN_CYCLES = 6;

   // Predicts the payload beats of the packetiser and checks them in order
   class rtp_beat_tracker;
      logic [PAYLOAD_BITS-1:0] max_payload;
      logic [STAMP_BITS-1:0]   stamp_step;
      logic [SEQ_BITS-1:0]     seq_initial;
      logic [STAMP_BITS-1:0]   stamp_initial;
      logic [LENGTH_BITS-1:0]  position;
      logic [LENGTH_BITS-1:0]  unit_len;
      logic [BYTE_BITS-1:0]    nal_header;
      bit                      fragmented;
      logic [PAYLOAD_BITS-1:0] fill;
      logic [SEQ_BITS-1:0]     seq;
      logic [STAMP_BITS-1:0]   stamp;
      rsp_payload_type         expected_beats[$];
      int                      failures;

      function new();
         max_payload   = MAX_PAYLOAD_RESET;
         stamp_step    = STAMP_STEP_RESET;
         seq_initial   = SEQ_INITIAL_RESET;
         stamp_initial = STAMP_INITIAL_RESET;
         position      = '0;
         unit_len      = '0;
         nal_header    = '0;
         fragmented    = 1'b0;
         fill          = '0;
         seq           = seq_initial;
         stamp         = stamp_initial;
         failures      = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] idx,
                                   logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            CSR_MAX_PAYLOAD: max_payload = data[PAYLOAD_BITS-1:0];
            CSR_STAMP_STEP:  stamp_step  = data[STAMP_BITS-1:0];
            CSR_SEQ_INITIAL: begin
               seq_initial = data[SEQ_BITS-1:0];
               seq         = seq_initial;
            end
            CSR_STAMP_INITIAL: begin
               stamp_initial = data[STAMP_BITS-1:0];
               stamp         = stamp_initial;
            end
            default: ;
         endcase
      endfunction

      function void push_beat(logic [BYTE_BITS-1:0] b, bit first, bit last);
         rsp_payload_type beat;
         beat.out_byte     = b;
         beat.packet_first = first;
         beat.packet_last  = last;
         beat.seq_number   = seq;
         beat.time_stamp   = stamp;
         expected_beats.push_back(beat);
      endfunction

      // Work out the beats that one accepted NAL byte causes
      function void accept_nal_byte(req_payload_type item);
         int                   limit;
         int                   p;
         bit                   unit_end;
         bit                   closing;
         logic [BYTE_BITS-1:0] fu_header;
         limit = (max_payload == 0) ? 1 : int'(max_payload);
         p     = int'(position);
         if (p == 0) begin
            unit_len   = (item.nal_length == 0) ? LENGTH_BITS'(1) : item.nal_length;
            nal_header = item.nal_byte;
            fill       = '0;
            fragmented = int'(unit_len) > limit;
         end
         unit_end = (p + 1 >= int'(unit_len));

         if (!fragmented) begin
            push_beat(item.nal_byte, p == 0, unit_end);
            if (unit_end) begin
               seq = seq + SEQ_BITS'(1);
               // parameter sets share the stamp of the picture that follows
               if ((nal_header & TYPE_MASK) != NAL_SPS && (nal_header & TYPE_MASK) != NAL_PPS)
                  stamp = stamp + stamp_step;
            end
         end else if (p != 0) begin
            // open a fragment with its indicator and FU header
            if (fill == 0) begin
               fu_header = nal_header & TYPE_MASK;
               if (p == 1)
                  fu_header = fu_header | FU_START;
               if (int'(unit_len) - p <= limit)
                  fu_header = fu_header | FU_END;
               push_beat((nal_header & NRI_MASK) | FU_A_TYPE, 1'b1, 1'b0);
               push_beat(fu_header, 1'b0, 1'b0);
            end
            closing = unit_end || (int'(fill) + 1 >= limit);
            push_beat(item.nal_byte, 1'b0, closing);
            if (closing) begin
               fill = '0;
               seq  = seq + SEQ_BITS'(1);
            end else begin
               fill = fill + PAYLOAD_BITS'(1);
            end
            if (unit_end)
               stamp = stamp + stamp_step;
         end

         if (unit_end) begin
            position = '0;
            fill     = '0;
         end else begin
            position = position + LENGTH_BITS'(1);
         end
      endfunction

      function void check_payload_beat(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_beats.size() == 0) begin
            $error("result beat with nothing expected: out_byte %0h", got.out_byte);
            failures++;
            return;
         end
         want = expected_beats.pop_front();
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
            failures++;
         end
         if (got.packet_first !== want.packet_first) begin
            $error("packet_first: expected %0b, got %0b", want.packet_first, got.packet_first);
            failures++;
         end
         if (got.packet_last !== want.packet_last) begin
            $error("packet_last: expected %0b, got %0b", want.packet_last, got.packet_last);
            failures++;
         end
         if (got.seq_number !== want.seq_number) begin
            $error("seq_number: expected %0h, got %0h", want.seq_number, got.seq_number);
            failures++;
         end
         if (got.time_stamp !== want.time_stamp) begin
            $error("time_stamp: expected %0h, got %0h", want.time_stamp, got.time_stamp);
            failures++;
         end
      endfunction

      function int outstanding();
         return expected_beats.size();
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   req_payload_type               req_payload = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   rsp_payload_type               rsp_payload;
   logic                          csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0]     csr_index = '0;
   logic [CSR_DATA_BITS-1:0]      csr_write_data = '0;

   rtp_beat_tracker tracker = new();
   int              cycle_count = 0;
   int              req_burst = 0;
   int              rsp_burst = 0;
   int              cur_payload = 1400;

   h264_nal_rtp_packetizer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial forever #10 clock = ~clock;

   // Observe every beat and register write on the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable)
            tracker.write_register(csr_index, csr_write_data);
         if (req_valid && !req_stall)
            tracker.accept_nal_byte(req_payload);
         if (rsp_valid && !rsp_stall)
            tracker.check_payload_beat(rsp_payload);
      end
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL h264_nal_rtp_packetizer");
         $finish;
      end
   end

   // Idle cycles before the next beat; occasional bursts with none
   function automatic int draw_wait(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0)
         burst = $urandom_range(8, 40);
      return $urandom_range(0, 13);
   endfunction

   // Receiver: stall a random number of cycles ahead of each beat
   initial begin
      int hold;
      wait (!reset);
      forever begin
         hold = draw_wait(rsp_burst);
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Offer one byte after a random gap and hold it until taken
   task automatic send_byte(input logic [BYTE_BITS-1:0] b, input logic [LENGTH_BITS-1:0] len);
      int gap;
      gap = draw_wait(req_burst);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= req_payload_type'{nal_byte: b, nal_length: len};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Header byte carries the length; the body carries noise in nal_length
   task automatic send_unit(input logic [BYTE_BITS-1:0] header, input int len,
                            output int count);
      int total;
      total = (len == 0) ? 1 : len;
      send_byte(header, LENGTH_BITS'(len));
      for (int i = 1; i < total; i++)
         send_byte(BYTE_BITS'($urandom), LENGTH_BITS'($urandom));
      count = total;
   endtask

   // Drop valid and let every expected beat come out
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_register(input logic [CSR_INDEX_BITS-1:0] idx,
                               input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_MAX_PAYLOAD)
         cur_payload = int'(data[PAYLOAD_BITS-1:0]);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 3))
         0:       return 32'h0;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'd3600;
         default: return $urandom;
      endcase
   endfunction

   // One random phase: new settings, then whole units, then drain
   task automatic random_phase(output int sent);
      int                      target;
      int                      len;
      int                      limit;
      int                      pick;
      int                      n;
      logic [BYTE_BITS-1:0]    header;
      logic [CSR_DATA_BITS-1:0] data;
      sent = 0;
      data = $urandom;
      case ($urandom_range(0, 9))
         0:       data[PAYLOAD_BITS-1:0] = '0;
         1:       data[PAYLOAD_BITS-1:0] = PAYLOAD_BITS'(1);
         2:       data[PAYLOAD_BITS-1:0] = PAYLOAD_BITS'(2);
         3:       data[PAYLOAD_BITS-1:0] = '1;
         4:       data[PAYLOAD_BITS-1:0] = PAYLOAD_BITS'(16);
         default: data[PAYLOAD_BITS-1:0] = PAYLOAD_BITS'($urandom_range(3, 24));
      endcase
      set_register(CSR_MAX_PAYLOAD, data);
      if ($urandom_range(0, 2) != 0)
         set_register(CSR_STAMP_STEP, pick_word());
      if ($urandom_range(0, 2) == 0) begin
         data = $urandom;
         if ($urandom_range(0, 1))
            data[SEQ_BITS-1:0] = SEQ_BITS'(16'hFFFF - $urandom_range(0, 3));
         set_register(CSR_SEQ_INITIAL, data);
      end
      if ($urandom_range(0, 3) == 0)
         set_register(CSR_STAMP_INITIAL, pick_word());

      limit  = (cur_payload == 0) ? 1 : cur_payload;
      target = $urandom_range(30, 80);
      while (sent < target) begin
         pick = $urandom_range(0, 9);
         if (pick == 0)
            len = $urandom_range(0, 1);
         else if (pick <= 4 || limit > 20)
            len = $urandom_range(1, (limit < 40) ? limit : 40);
         else if (pick <= 8)
            len = $urandom_range(limit + 1, 3 * limit + 1);
         else
            len = limit + $urandom_range(0, 1);
         header = BYTE_BITS'($urandom);
         if ($urandom_range(0, 3) == 0)
            header = (header & ~TYPE_MASK) | ($urandom_range(0, 1) ? NAL_SPS : NAL_PPS);
         send_unit(header, len, n);
         sent += n;
      end
      drain();
   endtask

   initial begin
      int n;
      int random_bytes;
      random_bytes = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Tiny payload, wrapping counters, zero length, SPS/PPS, one-fragment unit
      set_register(CSR_MAX_PAYLOAD, 32'd2);
      set_register(CSR_STAMP_STEP, 32'hFFFF_FFFF);
      set_register(CSR_SEQ_INITIAL, 32'h0000_FFFF);
      set_register(CSR_STAMP_INITIAL, 32'hFFFF_FFF0);
      send_unit(8'h00, 0, n);
      send_unit(8'hFF, 1, n);
      send_unit(8'h67, 2, n);
      send_unit(8'h68, 1, n);
      send_unit(8'h65, 3, n);
      send_unit(8'h41, 6, n);
      drain();

      // Zero payload limit acts as one byte per fragment; no stamp advance
      set_register(CSR_MAX_PAYLOAD, 32'd0);
      set_register(CSR_STAMP_STEP, 32'd0);
      send_unit(8'h7C, 3, n);
      drain();

      // Change the payload limit between fragments of a fragmented SPS
      set_register(CSR_MAX_PAYLOAD, 32'd4);
      set_register(CSR_STAMP_STEP, 32'd3600);
      send_byte(8'hE7, LENGTH_BITS'(10));
      repeat (4) send_byte(BYTE_BITS'($urandom), LENGTH_BITS'($urandom));
      drain();
      set_register(CSR_MAX_PAYLOAD, 32'd2);
      repeat (5) send_byte(BYTE_BITS'($urandom), LENGTH_BITS'($urandom));
      drain();

      while (random_bytes < RANDOM_BYTES) begin
         random_phase(n);
         random_bytes += n;
      end

      if (tracker.failures == 0)
         $display("PASS h264_nal_rtp_packetizer");
      else
         $display("FAIL h264_nal_rtp_packetizer");
      $finish;
   end

endmodule : testbench

`default_nettype wire
